@@ hw/rtl/sps_pkg.sv @@
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants for the sleep package scanner
// Word types for both channels, parse phase encoding and match constants.
// ----------------------------------------------------------------------------
package sps_pkg;

	localparam logic [31:0] NAME_WORD       = 32'h5F53_355F; // "_S5_"
	localparam logic [7:0]  PACKAGE_OP      = 8'h12;
	localparam logic [7:0]  BYTE_PREFIX     = 8'h0A;
	localparam int unsigned LEN_BYTES_SHIFT = 6;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic       found;
		logic [7:0] sleep_type;
	} out_word_t;

	typedef enum logic [2:0] {
		PH_SEARCH     = 3'd0,
		PH_AFTER_NAME = 3'd1,
		PH_LEN_FIRST  = 3'd2,
		PH_LEN_EXTRA  = 3'd3,
		PH_COUNT      = 3'd4,
		PH_ELEMENT    = 3'd5,
		PH_PREFIXED   = 3'd6
	} phase_t;

	// one staged byte handed from the input register to the parser
	typedef struct packed {
		logic     valid;
		in_word_t word;
	} staged_t;

	// parser result towards the output register
	typedef struct packed {
		logic      valid;
		out_word_t word;
	} result_t;

endpackage

@@ hw/rtl/sps_in_stage.sv @@
// ----------------------------------------------------------------------------
// sps_in_stage: input register
// Captures one byte word per cycle while byte_stall is low and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module sps_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  sps_pkg::in_word_t byte_word,
	input  logic              take,
	output sps_pkg::staged_t  staged
);

	logic              valid_s1;
	sps_pkg::in_word_t word_s1;
	logic              load;

	assign byte_stall = valid_s1 && !take;
	assign load       = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_s1 <= byte_word;
		end
	end

	assign staged.valid = valid_s1;
	assign staged.word  = word_s1;

endmodule

@@ hw/rtl/sps_parser.sv @@
// ----------------------------------------------------------------------------
// sps_parser: name search and package decode
// Keeps the byte window and parse phase, and decodes one byte per step.
// ----------------------------------------------------------------------------
module sps_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  sps_pkg::staged_t staged,
	output sps_pkg::result_t result
);

	logic [23:0]       recent_q, recent_d;
	sps_pkg::phase_t   phase_q, phase_d;
	logic [1:0]        skip_q, skip_d;
	logic              answered_q, answered_d;
	logic [7:0]        b;
	logic              last;
	logic [31:0]       window;
	logic              name_hit;
	logic              hit;
	logic [1:0]        skip_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q   <= '0;
			phase_q    <= sps_pkg::PH_SEARCH;
			skip_q     <= '0;
			answered_q <= 1'b0;
		end else if (step) begin
			recent_q   <= recent_d;
			phase_q    <= phase_d;
			skip_q     <= skip_d;
			answered_q <= answered_d;
		end
	end

	assign b        = staged.word.data_byte;
	assign last     = staged.word.last_byte;
	assign window   = {recent_q, b};
	assign name_hit = (window == sps_pkg::NAME_WORD);
	assign skip_dec = skip_q - 2'd1;

	always_comb begin
		phase_d    = phase_q;
		skip_d     = skip_q;
		answered_d = answered_q;
		recent_d   = window[23:0];
		hit        = 1'b0;

		if (!answered_q) begin
			case (phase_q)
				sps_pkg::PH_AFTER_NAME: begin
					if (b == sps_pkg::PACKAGE_OP) begin
						phase_d = sps_pkg::PH_LEN_FIRST;
					end else begin
						phase_d = name_hit ? sps_pkg::PH_AFTER_NAME : sps_pkg::PH_SEARCH;
					end
				end
				sps_pkg::PH_LEN_FIRST: begin
					skip_d  = b[sps_pkg::LEN_BYTES_SHIFT +: 2];
					phase_d = (b[sps_pkg::LEN_BYTES_SHIFT +: 2] == 2'd0) ?
						sps_pkg::PH_COUNT : sps_pkg::PH_LEN_EXTRA;
				end
				sps_pkg::PH_LEN_EXTRA: begin
					skip_d = skip_dec;
					if (skip_dec == 2'd0) begin
						phase_d = sps_pkg::PH_COUNT;
					end
				end
				sps_pkg::PH_COUNT: begin
					phase_d = sps_pkg::PH_ELEMENT;
				end
				sps_pkg::PH_ELEMENT: begin
					if (b == sps_pkg::BYTE_PREFIX) begin
						phase_d = sps_pkg::PH_PREFIXED;
					end else begin
						hit = 1'b1;
					end
				end
				sps_pkg::PH_PREFIXED: begin
					hit = 1'b1;
				end
				default: begin
					phase_d = name_hit ? sps_pkg::PH_AFTER_NAME : sps_pkg::PH_SEARCH;
				end
			endcase
		end

		if (hit) begin
			answered_d = 1'b1;
		end

		result.valid           = staged.valid && (hit || (last && !answered_q));
		result.word.found      = hit;
		result.word.sleep_type = hit ? b : 8'd0;

		// end of table: back to reset state
		if (last) begin
			recent_d   = '0;
			phase_d    = sps_pkg::PH_SEARCH;
			skip_d     = '0;
			answered_d = 1'b0;
		end
	end

endmodule

@@ hw/rtl/sps_out_stage.sv @@
// ----------------------------------------------------------------------------
// sps_out_stage: result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module sps_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  sps_pkg::result_t   result,
	output logic               room,
	output logic               result_valid,
	input  logic               result_stall,
	output sps_pkg::out_word_t result_word
);

	logic               valid_q;
	sps_pkg::out_word_t word_q;
	logic               load;

	assign room = !valid_q || !result_stall;
	assign load = step && result.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= result.word;
		end
	end

	assign result_valid = valid_q;
	assign result_word  = word_q;

endmodule

@@ hw/rtl/sleep_package_scanner.sv @@
// ----------------------------------------------------------------------------
// sleep_package_scanner: top level
// Streams a definition-table body and reports the _S5_ sleep type.
// ----------------------------------------------------------------------------
// Byte channel: one table byte per word, in order, last_byte set on the
// final byte. Result channel: exactly one word per table, found with the
// decoded sleep type, or found = 0 and sleep_type = 0 when the table ends
// without a complete package.
// A byte word is taken every cycle unless byte_stall is raised. The byte
// that completes a result is held in the input register; the parser then
// loads the result register, which drives result_valid. The decode step is
// a window compare and a phase update, so one byte is parsed per cycle
// while the receiver does not stall.
// When the receiver stalls with a result held, the parser stops, one byte
// waits in the input register and byte_stall is raised; nothing is lost.
// Reset clears the window, the parse phase and both valid flags; after the
// last byte of a table the parse state returns to the same values.
// ----------------------------------------------------------------------------
module sleep_package_scanner (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  sps_pkg::in_word_t  byte_word,
	output logic               result_valid,
	input  logic               result_stall,
	output sps_pkg::out_word_t result_word
);

	sps_pkg::staged_t staged;
	sps_pkg::result_t result;
	logic             room;
	logic             step;

	assign step = staged.valid && room;

	sps_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_word  (byte_word),
		.take       (step),
		.staged     (staged)
	);

	sps_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.staged (staged),
		.result (result)
	);

	sps_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.result       (result),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word)
	);

endmodule
